[rtl/core/spectral_peak_span_gate_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms for the peak span gate RTL.
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_PEAK_SPAN_GATE_CORE_MACROS_SVH
`define SPECTRAL_PEAK_SPAN_GATE_CORE_MACROS_SVH

// same-cycle implication
`define SPG_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("spg check failed");

// next-cycle implication
`define SPG_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("spg check failed");

`endif

[rtl/core/spg_pkg.sv]
// ---------------------------------------------------------------------------
// Peak span gate package
// Shared constants and types of the peak span gate.
// ---------------------------------------------------------------------------
package spg_pkg;

   localparam int WINDOW_RADIUS_DEF = 8;
   localparam int SAMPLE_WIDTH_DEF  = 24;
   localparam int AMOUNT_W          = 17;
   localparam int SPAN_OUT_W        = 5;
   localparam int GATE_W            = 17;
   localparam logic [AMOUNT_W-1:0] AMOUNT_ONE = 17'd65536;
   localparam logic [AMOUNT_W-1:0] AMOUNT_MIN = 17'd66;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

[rtl/core/spg_if.sv]
// ---------------------------------------------------------------------------
// Peak span gate channels
// Valid/ready channels for bins, results and the amount register.
// ---------------------------------------------------------------------------
interface spg_req_if #(parameter int SW = 24);
   logic          valid;
   logic          ready;
   logic [SW-1:0] bin_re;
   logic [SW-1:0] bin_im;
   logic          first_bin;
   logic          last_bin;
   modport source(output valid, bin_re, bin_im, first_bin, last_bin, input ready);
   modport sink(input valid, bin_re, bin_im, first_bin, last_bin, output ready);
endinterface

interface spg_rsp_if #(parameter int SW = 24);
   logic          valid;
   logic          ready;
   logic [SW-1:0] out_re;
   logic [SW-1:0] out_im;
   logic [4:0]    peak_span;
   logic          last_out;
   modport source(output valid, out_re, out_im, peak_span, last_out, input ready);
   modport sink(input valid, out_re, out_im, peak_span, last_out, output ready);
endinterface

interface spg_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] amount;
   modport source(output valid, amount, input ready);
   modport sink(input valid, amount, output ready);
endinterface

[rtl/core/spg_cell.sv]
// ---------------------------------------------------------------------------
// Peak span gate window cell
// One window slot: holds a bin and its squared magnitude, shifts from its
// neighbor, and flags whether it is louder than the center bin.
// ---------------------------------------------------------------------------
module spg_cell #(
   parameter int SW = spg_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spg_pkg::cell_ctrl_type ctrl,
   input  logic [SW-1:0]          nb_re,
   input  logic [SW-1:0]          nb_im,
   input  logic [2*SW-1:0]        nb_mag,
   input  logic                   nb_valid,
   input  logic [2*SW-1:0]        center_mag,
   output logic [SW-1:0]          re,
   output logic [SW-1:0]          im,
   output logic [2*SW-1:0]        mag,
   output logic                   valid,
   output logic                   louder
);
   import spg_pkg::*;

   logic [SW-1:0]   re_ff, re_in, im_ff, im_in;
   logic [2*SW-1:0] mag_ff, mag_in;
   logic            valid_ff, valid_in;

   always_comb begin
      re_in    = re_ff;
      im_in    = im_ff;
      mag_in   = mag_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         mag_in   = '0;
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         re_in    = nb_re;
         im_in    = nb_im;
         mag_in   = nb_mag;
         valid_in = nb_valid;
      end
   end

   always_ff @(posedge clock) begin
      re_ff <= re_in;
      im_ff <= im_in;
      if (reset) begin
         mag_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         mag_ff   <= mag_in;
         valid_ff <= valid_in;
      end
   end

   assign re     = re_ff;
   assign im     = im_ff;
   assign mag    = mag_ff;
   assign valid  = valid_ff;
   assign louder = center_mag < mag_ff;

endmodule

[rtl/core/spg_gate.sv]
// ---------------------------------------------------------------------------
// Peak span gate arithmetic
// Maps the amount to a span threshold and applies the inverted smoothstep
// gate to one bin over a four-stage pipeline.
// ---------------------------------------------------------------------------
module spg_gate #(
   parameter int RADIUS = spg_pkg::WINDOW_RADIUS_DEF,
   parameter int SW     = spg_pkg::SAMPLE_WIDTH_DEF,
   parameter int SPAN_W = $clog2(2*RADIUS+1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [spg_pkg::AMOUNT_W-1:0]  amount,
   input  logic                          start,
   input  logic [SPAN_W-1:0]             span,
   input  logic [SW-1:0]                 bin_re,
   input  logic [SW-1:0]                 bin_im,
   input  logic                          last,
   output logic                          done,
   output logic [SW-1:0]                 out_re,
   output logic [SW-1:0]                 out_im,
   output logic [SPAN_W-1:0]             out_span,
   output logic                          out_last
);
   import spg_pkg::*;

   localparam int T1_W   = 37;
   localparam int T2_W   = T1_W + $clog2(2*RADIUS) + 1;
   localparam int THR_W  = T2_W - 19;
   localparam int DIF_W  = THR_W + 2;
   localparam int SS_W   = 34;
   localparam int C_W    = 18;
   localparam int P_W    = SS_W + C_W;
   localparam int X_W    = SW + GATE_W + 1;

   // threshold path
   logic [AMOUNT_W-1:0] a_sat;
   logic [T1_W-1:0]     t1_ff, t1_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic                small_ff, small_in;
   logic [T2_W-1:0]     t2;

   always_comb begin
      a_sat    = (amount > AMOUNT_ONE) ? AMOUNT_ONE : amount;
      small_in = a_sat < AMOUNT_MIN;
      t1_in    = T1_W'(a_sat) * (T1_W'(a_sat) * T1_W'(5) + T1_W'(196608));
      t2       = T2_W'(t1_ff) * T2_W'(2*RADIUS) + (T2_W'(1) << 18);
      thr_in   = THR_W'(t2 >> 19);
   end

   always_ff @(posedge clock) begin
      t1_ff    <= t1_in;
      thr_ff   <= thr_in;
      small_ff <= small_in;
   end

   // stage valid chain
   logic [3:0] v_ff, v_in;
   assign v_in = {v_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   // payload carried along
   logic [SW-1:0]     re_ff [3], im_ff [3];
   logic [SPAN_W-1:0] sp_ff [4];
   logic              lt_ff [4];

   // stage 1: difference and clamp
   logic signed [DIF_W-1:0] dif;
   logic [AMOUNT_W-1:0]     s1_ff, s1_in;
   logic                    pass1_ff, pass1_in;

   always_comb begin
      dif      = $signed({2'b00, thr_ff}) - $signed(DIF_W'(span) << 16);
      pass1_in = small_ff || (dif <= 0);
      if (pass1_in) s1_in = '0;
      else if ((dif >>> 1) > $signed(DIF_W'(AMOUNT_ONE))) s1_in = AMOUNT_ONE;
      else s1_in = AMOUNT_W'(dif >>> 1);
   end

   // stage 2: square and cubic coefficient
   logic [SS_W-1:0] ss_ff, ss_in;
   logic [C_W-1:0]  c_ff, c_in;
   logic            pass2_ff;

   always_comb begin
      ss_in = SS_W'(s1_ff) * SS_W'(s1_ff);
      c_in  = C_W'(196608) - (C_W'(s1_ff) << 1);
   end

   // stage 3: gate
   logic [P_W-1:0]    prod;
   logic [GATE_W-1:0] g_ff, g_in;

   always_comb begin
      prod = P_W'(ss_ff) * P_W'(c_ff) + (P_W'(1) << 31);
      g_in = pass2_ff ? AMOUNT_ONE : GATE_W'(AMOUNT_ONE - GATE_W'(prod >> 32));
   end

   // stage 4: apply
   logic signed [X_W-1:0] xr, xi;
   logic [SW-1:0]         or_ff, oi_ff;

   always_comb begin
      xr = $signed(X_W'($signed(re_ff[2]))) * $signed(X_W'(g_ff)) + X_W'(32768);
      xi = $signed(X_W'($signed(im_ff[2]))) * $signed(X_W'(g_ff)) + X_W'(32768);
   end

   always_ff @(posedge clock) begin
      re_ff[0] <= bin_re;    im_ff[0] <= bin_im;
      re_ff[1] <= re_ff[0];  im_ff[1] <= im_ff[0];
      re_ff[2] <= re_ff[1];  im_ff[2] <= im_ff[1];
      sp_ff[0] <= span;      lt_ff[0] <= last;
      sp_ff[1] <= sp_ff[0];  lt_ff[1] <= lt_ff[0];
      sp_ff[2] <= sp_ff[1];  lt_ff[2] <= lt_ff[1];
      sp_ff[3] <= sp_ff[2];  lt_ff[3] <= lt_ff[2];
      s1_ff    <= s1_in;
      pass1_ff <= pass1_in;
      ss_ff    <= ss_in;
      c_ff     <= c_in;
      pass2_ff <= pass1_ff;
      g_ff     <= g_in;
      or_ff    <= SW'(xr >>> 16);
      oi_ff    <= SW'(xi >>> 16);
   end

   assign done     = v_ff[3];
   assign out_re   = or_ff;
   assign out_im   = oi_ff;
   assign out_span = sp_ff[3];
   assign out_last = lt_ff[3];

endmodule

[rtl/core/spectral_peak_span_gate_core.sv]
// ---------------------------------------------------------------------------
// Spectral peak span gate core
// Window of 2R+1 cells around a center bin; counts the quiet span on both
// sides and gates bins whose span is below the amount-derived threshold.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one complex bin per transfer with first_bin/last_bin marks.
//   rsp carries the gated bin delayed by RADIUS bins, its peak_span, and
//   last_out on the final result of a frame. csr writes amount at any time
//   the core is idle; it is always ready and the new amount is registered.
// Timing:
//   A bin without a result goes through load, shift and evaluate; one with
//   a result also passes through the four-stage gate pipeline. A last_bin
//   adds RADIUS further shift/evaluate steps to flush the window, then
//   clears it.
//   req.ready is high only between items.
// Reset:
//   Synchronous reset empties the window and sets amount to zero.
// Stall:
//   A result sits in the output register until rsp.ready; the core keeps
//   shifting but holds before the next evaluation until the register frees.
// ---------------------------------------------------------------------------
module spectral_peak_span_gate_core #(
   parameter int RADIUS = spg_pkg::WINDOW_RADIUS_DEF,
   parameter int SW     = spg_pkg::SAMPLE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   spg_req_if.sink   req,
   spg_rsp_if.source rsp,
   spg_csr_if.sink   csr
);
   import spg_pkg::*;
   `include "spectral_peak_span_gate_core_macros.svh"

   localparam int DEPTH  = 2*RADIUS + 1;
   localparam int SPAN_W = $clog2(2*RADIUS+1);
   localparam int FL_W   = $clog2(RADIUS+1);
   localparam int ST_W   = 2;
   localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0] ST_PUSH = 2'd1;
   localparam logic [ST_W-1:0] ST_EVAL = 2'd2;
   localparam logic [ST_W-1:0] ST_GATE = 2'd3;

   logic [ST_W-1:0]     state_ff, state_in;
   logic [SW-1:0]       bin_re_ff, bin_re_in, bin_im_ff, bin_im_in;
   logic                first_ff, first_in, last_ff, last_in;
   logic                push_valid_ff, push_valid_in;
   logic [FL_W-1:0]     flush_ff, flush_in;
   logic [AMOUNT_W-1:0] amount_ff, amount_in;

   // window chain
   logic [SW-1:0]   c_re [DEPTH+1];
   logic [SW-1:0]   c_im [DEPTH+1];
   logic [2*SW-1:0] c_mag [DEPTH+1];
   logic            c_valid [DEPTH+1];
   logic [DEPTH-1:0] louder;
   cell_ctrl_type   ctrl, top_ctrl;
   logic signed [2*SW-1:0] sq_re, sq_im;

   always_comb begin
      sq_re = $signed(bin_re_ff) * $signed(bin_re_ff);
      sq_im = $signed(bin_im_ff) * $signed(bin_im_ff);
   end

   assign c_re[DEPTH]    = bin_re_ff;
   assign c_im[DEPTH]    = bin_im_ff;
   assign c_mag[DEPTH]   = push_valid_ff ? (2*SW)'(sq_re) + (2*SW)'(sq_im) : '0;
   assign c_valid[DEPTH] = push_valid_ff;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         spg_cell #(.SW(SW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       ((gi == DEPTH-1) ? top_ctrl : ctrl),
            .nb_re      (c_re[gi+1]),
            .nb_im      (c_im[gi+1]),
            .nb_mag     (c_mag[gi+1]),
            .nb_valid   (c_valid[gi+1]),
            .center_mag (c_mag[RADIUS]),
            .re         (c_re[gi]),
            .im         (c_im[gi]),
            .mag        (c_mag[gi]),
            .valid      (c_valid[gi]),
            .louder     (louder[gi])
         );
      end
   endgenerate

   // span search
   logic [SPAN_W-1:0] fwd, bwd, span;

   always_comb begin
      fwd = SPAN_W'(RADIUS);
      bwd = SPAN_W'(RADIUS);
      for (int k = RADIUS; k >= 1; k--) begin
         if (louder[RADIUS+k]) fwd = SPAN_W'(k-1);
         if (louder[RADIUS-k]) bwd = SPAN_W'(k-1);
      end
      span = fwd + bwd;
   end

   // gate unit
   logic              gate_start, gate_done, gate_last;
   logic [SW-1:0]     g_re, g_im;
   logic [SPAN_W-1:0] g_span;

   spg_gate #(.RADIUS(RADIUS), .SW(SW), .SPAN_W(SPAN_W)) u_gate (
      .clock    (clock),
      .reset    (reset),
      .amount   (amount_ff),
      .start    (gate_start),
      .span     (span),
      .bin_re   (c_re[RADIUS]),
      .bin_im   (c_im[RADIUS]),
      .last     (last_ff && (flush_ff == '0)),
      .done     (gate_done),
      .out_re   (g_re),
      .out_im   (g_im),
      .out_span (g_span),
      .out_last (gate_last)
   );

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]     rsp_re_ff, rsp_im_ff;
   logic [SPAN_W-1:0] rsp_span_ff;
   logic              rsp_last_ff;
   logic              out_free, step_done, end_clear;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign gate_start = (state_ff == ST_EVAL) && c_valid[RADIUS] && out_free;
   assign step_done  = ((state_ff == ST_EVAL) && !c_valid[RADIUS]) || gate_done;
   assign end_clear  = step_done && (flush_ff == '0) && last_ff;

   always_comb begin
      ctrl.shift     = state_ff == ST_PUSH;
      ctrl.clear     = ((state_ff == ST_PUSH) && push_valid_ff && first_ff) || end_clear;
      top_ctrl.shift = ctrl.shift;
      top_ctrl.clear = ctrl.clear && !ctrl.shift;
   end

   always_comb begin
      state_in      = state_ff;
      bin_re_in     = bin_re_ff;
      bin_im_in     = bin_im_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      push_valid_in = push_valid_ff;
      flush_in      = flush_ff;
      amount_in     = (csr.valid && csr.ready) ? csr.amount : amount_ff;
      rsp_valid_in  = gate_done ? 1'b1 : ((rsp_valid_ff && rsp.ready) ? 1'b0 : rsp_valid_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               bin_re_in     = req.bin_re;
               bin_im_in     = req.bin_im;
               first_in      = req.first_bin;
               last_in       = req.last_bin;
               push_valid_in = 1'b1;
               flush_in      = req.last_bin ? FL_W'(RADIUS) : '0;
               state_in      = ST_PUSH;
            end
         end
         ST_PUSH: state_in = ST_EVAL;
         ST_EVAL: begin
            if (gate_start) state_in = ST_GATE;
         end
         ST_GATE: ;
         default: state_in = ST_IDLE;
      endcase
      if (step_done) begin
         if (flush_ff != '0) begin
            flush_in      = flush_ff - FL_W'(1);
            push_valid_in = 1'b0;
            bin_re_in     = '0;
            bin_im_in     = '0;
            state_in      = ST_PUSH;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_re_ff <= bin_re_in;
      bin_im_ff <= bin_im_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      flush_ff  <= flush_in;
      if (gate_done) begin
         rsp_re_ff   <= g_re;
         rsp_im_ff   <= g_im;
         rsp_span_ff <= g_span;
         rsp_last_ff <= gate_last;
      end
      if (reset) begin
         state_ff      <= ST_IDLE;
         push_valid_ff <= 1'b0;
         amount_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         push_valid_ff <= push_valid_in;
         amount_ff     <= amount_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req.ready     = state_ff == ST_IDLE;
   assign csr.ready     = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_re    = rsp_re_ff;
   assign rsp.out_im    = rsp_im_ff;
   assign rsp.peak_span = SPAN_OUT_W'(rsp_span_ff);
   assign rsp.last_out  = rsp_last_ff;

   `SPG_ASSERT_IMPLY(a_done_in_gate, clock, reset, gate_done, state_ff == ST_GATE)
   `SPG_ASSERT_IMPLY(a_last_step_emits, clock, reset,
      (state_ff == ST_EVAL) && last_ff && (flush_ff == '0), c_valid[RADIUS])
   `SPG_ASSERT_NEXT(a_start_reaches_gate, clock, reset, gate_start, state_ff == ST_GATE)

endmodule
